>>> rtl/core/xxhash64_stream_defines.svh
// Assertion macros for the xxHash64 stream block
`ifndef XXHASH64_STREAM_DEFINES_SVH
`define XXHASH64_STREAM_DEFINES_SVH
// Implication checked on every clock edge outside reset
`define XH_ASSERT_IMP(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");
// Next-cycle implication checked outside reset
`define XH_ASSERT_NXT(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");
`endif

>>> rtl/core/xh64_pkg.sv
// Package with xxHash64 constants, types and helper functions
`timescale 1ns / 1ps
`default_nettype none
package xh64_pkg;
    localparam logic [63:0] P1 = 64'h9E3779B185EBCA87;
    localparam logic [63:0] P2 = 64'hC2B2AE3D27D4EB4F;
    localparam logic [63:0] P3 = 64'h165667B19E3779F9;
    localparam logic [63:0] P4 = 64'h85EBCA77C2B2AE63;
    localparam logic [63:0] P5 = 64'h27D4EB2F165667C5;
    localparam int BLOCK_BYTES = 32;
    localparam logic [63:0] SEED_RESET = 64'd0;

    // commands from the controller to the datapath
    typedef struct packed {
        logic restart;      // reload lanes from seed, clear counts
        logic load;         // take one input beat into the buffer
        logic lane_step;    // run one lane round (lane index in sel)
        logic merge_init;   // h = rotation sum, or seed + P5
        logic merge_step;   // merge one accumulator (sel)
        logic add_len;      // h += total length
        logic tail8;        // fold 8 tail bytes
        logic tail4;        // fold 4 tail bytes
        logic tail1;        // fold 1 tail byte
        logic aval;         // final avalanche
        logic hold;         // multiplier first cycle, state unchanged
        logic [1:0] sel;
        logic [1:0] phase;  // sub-step of a multi-cycle operation
    } t_cmd;

    typedef struct packed {
        logic block_full;   // 32 bytes buffered
        logic long_msg;     // total length >= 32
        logic [5:0] left;   // tail bytes not yet folded
    } t_stat;

    function automatic logic [63:0] rotl64(input logic [63:0] v, input int n);
        rotl64 = (v << n) | (v >> (64 - n));
    endfunction
endpackage
`default_nettype wire

>>> rtl/core/xh64_if.sv
// Valid/ready stream interfaces for the input beats, results and seed writes
`timescale 1ns / 1ps
`default_nettype none
interface xh64_in_if;
    logic        valid;
    logic        ready;
    logic [63:0] data;
    logic [3:0]  byte_count;
    logic        last;
    modport source (output valid, data, byte_count, last, input ready);
    modport sink   (input valid, data, byte_count, last, output ready);
endinterface

interface xh64_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] hash;
    modport source (output valid, hash, input ready);
    modport sink   (input valid, hash, output ready);
endinterface

interface xh64_cfg_if;
    logic        valid;
    logic        ready;
    logic [63:0] data;
    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface
`default_nettype wire

>>> rtl/core/xh64_datapath.sv
// xxHash64 datapath: block buffer, lanes, length and one shared multiplier
`timescale 1ns / 1ps
`default_nettype none
module xh64_datapath
    import xh64_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire t_cmd        i_cmd,
    input  wire logic [63:0] i_seed,
    input  wire logic [63:0] i_data,
    input  wire logic [3:0]  i_byte_count,
    output t_stat            o_stat,
    output logic [63:0]      o_hash
);
    logic [7:0]  r_buf [BLOCK_BYTES];
    logic [7:0]  r_spill [8];   // bytes past the block end, moved to the front after the block
    logic [63:0] r_acc [4];
    logic [5:0]  r_fill;
    logic [4:0]  r_pos;
    logic [63:0] r_len;
    logic [63:0] r_h;
    logic [63:0] r_t;     // intermediate between multiplies
    logic [63:0] r_pp_lo;
    logic [31:0] r_pp_hi;

    logic [3:0]  cnt;
    logic [63:0] lane_word;
    logic [63:0] tail_word;
    logic [63:0] mul_a;
    logic [63:0] mul_b;
    logic [63:0] prod;
    logic [5:0]  n_fill;
    logic [5:0]  wr_idx [8];

    always_comb begin
        cnt = (i_byte_count > 4'd8) ? 4'd8 : i_byte_count;
        for (int k = 0; k < 8; k++) begin
            lane_word[8*k +: 8] = r_buf[{i_cmd.sel, 3'(k)}];
            tail_word[8*k +: 8] = r_buf[r_pos + 5'(k)];
            wr_idx[k] = r_fill + 6'(k);
        end
        n_fill = r_fill + 6'(cnt);
    end

    // one shared multiplier, operands chosen by the current operation
    always_comb begin
        mul_a = r_t;
        mul_b = P1;
        if (i_cmd.lane_step || i_cmd.merge_step || i_cmd.tail8) begin
            unique case (i_cmd.phase)
                2'd0: begin
                    mul_a = i_cmd.lane_step ? lane_word :
                            i_cmd.merge_step ? r_acc[i_cmd.sel] : tail_word;
                    mul_b = P2;
                end
                default: begin
                    mul_a = r_t;
                    mul_b = P1;
                end
            endcase
        end else if (i_cmd.tail4) begin
            mul_a = (i_cmd.phase == 2'd0) ? {32'd0, tail_word[31:0]} : r_t;
            mul_b = (i_cmd.phase == 2'd0) ? P1 : P2;
        end else if (i_cmd.tail1) begin
            mul_a = (i_cmd.phase == 2'd0) ? {56'd0, tail_word[7:0]} : r_t;
            mul_b = (i_cmd.phase == 2'd0) ? P5 : P1;
        end else if (i_cmd.aval) begin
            mul_a = r_t;
            mul_b = (i_cmd.phase == 2'd1) ? P2 : P3;
        end
        prod = r_pp_lo + {r_pp_hi, 32'd0};
    end

    // low 64 bits of the product, 32-bit partial products registered
    always_ff @(posedge i_clk) begin
        r_pp_lo <= 64'(mul_a[31:0]) * 64'(mul_b[31:0]);
        r_pp_hi <= mul_a[31:0] * mul_b[63:32] + mul_a[63:32] * mul_b[31:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.restart) begin
            r_acc[0] <= i_seed + P1 + P2;
            r_acc[1] <= i_seed + P2;
            r_acc[2] <= i_seed;
            r_acc[3] <= i_seed - P1;
            r_fill   <= '0;
            r_len    <= '0;
            r_pos    <= '0;
        end else if (!i_cmd.hold) begin
            if (i_cmd.load) begin
                for (int k = 0; k < 8; k++) begin
                    if (4'(k) < cnt) begin
                        if (wr_idx[k] < 6'(BLOCK_BYTES)) begin
                            r_buf[wr_idx[k][4:0]] <= i_data[8*k +: 8];
                        end else begin
                            r_spill[wr_idx[k][2:0]] <= i_data[8*k +: 8];
                        end
                    end
                end
                r_fill <= n_fill;
                r_len  <= r_len + 64'(cnt);
            end
            if (i_cmd.lane_step) begin
                unique case (i_cmd.phase)
                    2'd0: r_t <= rotl64(r_acc[i_cmd.sel] + prod, 31);
                    default: begin
                        r_acc[i_cmd.sel] <= prod;
                        if (i_cmd.sel == 2'd3) begin
                            // spill-over bytes of the last beat move to the front
                            for (int k = 0; k < 8; k++) begin
                                r_buf[5'(k)] <= r_spill[3'(k)];
                            end
                            r_fill <= r_fill - 6'(BLOCK_BYTES);
                        end
                    end
                endcase
            end
            if (i_cmd.merge_init) begin
                r_pos <= '0;
                if (o_stat.long_msg) begin
                    r_h <= rotl64(r_acc[0], 1) + rotl64(r_acc[1], 7)
                         + rotl64(r_acc[2], 12) + rotl64(r_acc[3], 18);
                end else begin
                    r_h <= i_seed + P5;
                end
            end
            if (i_cmd.merge_step) begin
                unique case (i_cmd.phase)
                    2'd0: r_t <= rotl64(prod, 31);
                    2'd1: r_t <= r_h ^ prod;
                    default: r_h <= prod + P4;
                endcase
            end
            if (i_cmd.add_len) r_h <= r_h + r_len;
            if (i_cmd.tail8) begin
                unique case (i_cmd.phase)
                    2'd0: r_t <= rotl64(prod, 31);
                    2'd1: r_t <= rotl64(r_h ^ prod, 27);
                    default: begin
                        r_h    <= prod + P4;
                        r_pos  <= r_pos + 5'd8;
                        r_fill <= r_fill - 6'd8;
                    end
                endcase
            end
            if (i_cmd.tail4) begin
                if (i_cmd.phase == 2'd0) begin
                    r_t <= rotl64(r_h ^ prod, 23);
                end else begin
                    r_h    <= prod + P3;
                    r_pos  <= r_pos + 5'd4;
                    r_fill <= r_fill - 6'd4;
                end
            end
            if (i_cmd.tail1) begin
                if (i_cmd.phase == 2'd0) begin
                    r_t <= rotl64(r_h ^ prod, 11);
                end else begin
                    r_h    <= prod;
                    r_pos  <= r_pos + 5'd1;
                    r_fill <= r_fill - 6'd1;
                end
            end
            if (i_cmd.aval) begin
                unique case (i_cmd.phase)
                    2'd0: r_t <= r_h ^ (r_h >> 33);
                    2'd1: r_t <= prod ^ (prod >> 29);
                    default: r_h <= prod ^ (prod >> 32);
                endcase
            end
        end
    end

    // the fill can reach 39 bytes; bytes past the block end wait in r_spill
    assign o_stat.block_full = (r_fill >= 6'(BLOCK_BYTES));
    assign o_stat.long_msg   = (r_len >= 64'(BLOCK_BYTES));
    assign o_stat.left       = r_fill;
    assign o_hash            = r_h;
endmodule
`default_nettype wire

>>> rtl/core/xh64_ctrl.sv
// xxHash64 controller: sequences block rounds, merge, tail folds and avalanche
`timescale 1ns / 1ps
`default_nettype none
`include "xxhash64_stream_defines.svh"
module xh64_ctrl
    import xh64_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_in_valid,
    input  wire logic  i_in_last,
    output logic       o_in_ready,
    input  wire logic  i_cfg_valid,
    output logic       o_cfg_ready,
    output logic       o_out_valid,
    input  wire logic  i_out_ready,
    input  wire t_stat i_stat,
    output t_cmd       o_cmd
);
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_BLOCK = 4'd1;
    localparam logic [3:0] S_MINIT = 4'd2;
    localparam logic [3:0] S_MERGE = 4'd3;
    localparam logic [3:0] S_LEN   = 4'd4;
    localparam logic [3:0] S_T8    = 4'd5;
    localparam logic [3:0] S_T4    = 4'd6;
    localparam logic [3:0] S_T1    = 4'd7;
    localparam logic [3:0] S_AVAL  = 4'd8;
    localparam logic [3:0] S_OUT   = 4'd9;

    logic [3:0] r_state, n_state;
    logic [1:0] r_sel, n_sel;
    logic [1:0] r_ph, n_ph;
    logic       r_last, n_last;
    logic       r_wait, n_wait;
    logic       mul_op;
    logic       in_fire;

    assign o_in_ready  = (r_state == S_IDLE) && !i_stat.block_full && !r_last && !i_cfg_valid;
    assign o_cfg_ready = (r_state == S_IDLE) && !i_stat.block_full && !r_last;
    assign o_out_valid = (r_state == S_OUT);
    assign in_fire     = i_in_valid && o_in_ready;

    always_comb begin
        n_state = r_state;
        n_sel   = r_sel;
        n_ph    = r_ph;
        n_last  = r_last;
        o_cmd   = '0;
        o_cmd.sel   = r_sel;
        o_cmd.phase = r_ph;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.restart = i_cfg_valid && o_cfg_ready;
                o_cmd.load    = in_fire;
                if (i_stat.block_full) begin
                    n_state = S_BLOCK;
                    n_sel   = 2'd0;
                    n_ph    = 2'd0;
                end else if (in_fire) begin
                    n_last = i_in_last;
                end else if (r_last) begin
                    n_state = S_MINIT;
                end
            end
            S_BLOCK: begin
                o_cmd.lane_step = 1'b1;
                if (r_ph == 2'd0) begin
                    n_ph = 2'd1;
                end else begin
                    n_ph  = 2'd0;
                    n_sel = r_sel + 2'd1;
                    if (r_sel == 2'd3) n_state = S_IDLE;
                end
            end
            S_MINIT: begin
                o_cmd.merge_init = 1'b1;
                n_sel = 2'd0;
                n_ph  = 2'd0;
                n_state = i_stat.long_msg ? S_MERGE : S_LEN;
            end
            S_MERGE: begin
                o_cmd.merge_step = 1'b1;
                if (r_ph != 2'd2) begin
                    n_ph = r_ph + 2'd1;
                end else begin
                    n_ph  = 2'd0;
                    n_sel = r_sel + 2'd1;
                    if (r_sel == 2'd3) n_state = S_LEN;
                end
            end
            S_LEN: begin
                o_cmd.add_len = 1'b1;
                n_ph = 2'd0;
                n_state = S_T8;
            end
            S_T8: begin
                if (i_stat.left >= 6'd8) begin
                    o_cmd.tail8 = 1'b1;
                    n_ph = (r_ph == 2'd2) ? 2'd0 : r_ph + 2'd1;
                end else begin
                    n_state = S_T4;
                end
            end
            S_T4: begin
                if (i_stat.left >= 6'd4) begin
                    o_cmd.tail4 = 1'b1;
                    n_ph = r_ph + 2'd1;
                    if (r_ph == 2'd1) begin
                        n_ph = 2'd0;
                        n_state = S_T1;
                    end
                end else begin
                    n_state = S_T1;
                end
            end
            S_T1: begin
                if (i_stat.left != 6'd0) begin
                    o_cmd.tail1 = 1'b1;
                    n_ph = (r_ph == 2'd1) ? 2'd0 : 2'd1;
                end else begin
                    n_state = S_AVAL;
                end
            end
            S_AVAL: begin
                o_cmd.aval = 1'b1;
                n_ph = r_ph + 2'd1;
                if (r_ph == 2'd2) begin
                    n_ph = 2'd0;
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (i_out_ready) begin
                    o_cmd.restart = 1'b1;
                    n_last  = 1'b0;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase

        // every multiply holds the state while its partial products are registered
        mul_op = o_cmd.lane_step || o_cmd.merge_step || o_cmd.tail8 || o_cmd.tail4
              || o_cmd.tail1 || (o_cmd.aval && r_ph != 2'd0);
        n_wait = 1'b0;
        if (mul_op && !r_wait) begin
            o_cmd.hold = 1'b1;
            n_wait  = 1'b1;
            n_state = r_state;
            n_sel   = r_sel;
            n_ph    = r_ph;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_sel   <= '0;
            r_ph    <= '0;
            r_last  <= 1'b0;
            r_wait  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_sel   <= n_sel;
            r_ph    <= n_ph;
            r_last  <= (i_cfg_valid && o_cfg_ready) ? 1'b0 : n_last;
            r_wait  <= n_wait;
        end
    end

    `XH_ASSERT_IMP(a_no_in_busy, i_clk, i_rst_n, r_state != S_IDLE, !o_in_ready)
    `XH_ASSERT_IMP(a_full_blocks, i_clk, i_rst_n, i_stat.block_full, !o_in_ready)
    `XH_ASSERT_NXT(a_out_done, i_clk, i_rst_n, o_out_valid && i_out_ready,
        r_state == S_IDLE && !r_last)
endmodule
`default_nettype wire

>>> rtl/core/xxhash64_stream.sv
// A beat goes into the block buffer; a beat that completes a block starts the block rounds
// (4 lanes x 2 multiplies), while input is held. After a last beat come the merge (from 32
// bytes up), length add, the 8-byte, 4-byte and single-byte tail folds and the avalanche.
// Each multiply registers partial products first; input waits until the hash beat is taken.
// Reset (synchronous, active low) sets seed SEED_INIT (0 by default) and reloads the lanes.
// Top level of the streaming xxHash64 block
`timescale 1ns / 1ps
`default_nettype none
module xxhash64_stream
    import xh64_pkg::*;
#(
    parameter logic [63:0] SEED_INIT = SEED_RESET
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    xh64_in_if.sink   in_ch,
    xh64_out_if.source out_ch,
    xh64_cfg_if.sink  cfg_ch
);
    logic [63:0] r_seed;
    t_cmd  cmd;
    t_stat stat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_seed <= SEED_INIT;
        else if (cfg_ch.valid && cfg_ch.ready) r_seed <= cfg_ch.data;
    end

    // restart on a seed write uses the new seed directly
    logic [63:0] seed_now;
    assign seed_now = (cfg_ch.valid && cfg_ch.ready) ? cfg_ch.data : r_seed;

    xh64_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_ch.valid), .i_in_last(in_ch.last), .o_in_ready(in_ch.ready),
        .i_cfg_valid(cfg_ch.valid), .o_cfg_ready(cfg_ch.ready),
        .o_out_valid(out_ch.valid), .i_out_ready(out_ch.ready),
        .i_stat(stat), .o_cmd(cmd)
    );

    xh64_datapath u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(cmd),
        .i_seed(!i_rst_n ? SEED_INIT : seed_now),
        .i_data(in_ch.data), .i_byte_count(in_ch.byte_count),
        .o_stat(stat), .o_hash(out_ch.hash)
    );
endmodule
`default_nettype wire

>>> bench/tb.sv
// Self-checking testbench for the streaming xxHash64 block
`timescale 1ns / 1ps
module tb;
    import xh64_pkg::*;

    typedef struct {
        logic [63:0] data;
        logic [3:0]  cnt;
        logic        last;
    } beat_t;

    localparam int DRAIN_CYCLES = 80;
    localparam int STALL_LIMIT  = 3000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    xh64_in_if  in_ch();
    xh64_out_if out_ch();
    xh64_cfg_if cfg_ch();

    xxhash64_stream DUT (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch),
        .cfg_ch (cfg_ch)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    beat_t       pending[$];
    logic [63:0] hash_q[$];
    int          errors = 0;
    bit          in_taken = 0;
    bit          cfg_taken = 0;
    int          idle_cycles = 0;

    // hash state mirror
    logic [63:0] seed_r = 64'd0;
    logic [63:0] acc[4];
    logic [7:0]  blk[32];
    int          fill;
    logic [63:0] msg_len;

    function automatic logic [63:0] rol(input logic [63:0] v, input int n);
        return (v << n) | (v >> (64 - n));
    endfunction

    function automatic logic [63:0] lane_rnd(input logic [63:0] a, input logic [63:0] x);
        logic [63:0] t;
        t = a + x * P2;
        return rol(t, 31) * P1;
    endfunction

    function automatic logic [63:0] blk_word(input int pos, input int nb);
        logic [63:0] v;
        v = 64'd0;
        for (int i = 0; i < nb; i++) v[8*i +: 8] = blk[pos + i];
        return v;
    endfunction

    function automatic void reseed();
        acc[0] = seed_r + P1 + P2;
        acc[1] = seed_r + P2;
        acc[2] = seed_r;
        acc[3] = seed_r - P1;
        fill = 0;
        msg_len = 64'd0;
    endfunction

    function automatic logic [63:0] finish_hash();
        logic [63:0] h;
        int pos;
        int left;
        pos = 0;
        left = fill;
        if (msg_len >= 64'd32) begin
            h = rol(acc[0], 1) + rol(acc[1], 7) + rol(acc[2], 12) + rol(acc[3], 18);
            for (int k = 0; k < 4; k++) h = (h ^ lane_rnd(64'd0, acc[k])) * P1 + P4;
        end else begin
            h = seed_r + P5;
        end
        h += msg_len;
        while (left >= 8) begin
            h ^= lane_rnd(64'd0, blk_word(pos, 8));
            h = rol(h, 27) * P1 + P4;
            pos += 8;
            left -= 8;
        end
        if (left >= 4) begin
            h ^= blk_word(pos, 4) * P1;
            h = rol(h, 23) * P2 + P3;
            pos += 4;
            left -= 4;
        end
        while (left > 0) begin
            h ^= {56'd0, blk[pos]} * P5;
            h = rol(h, 11) * P1;
            pos++;
            left--;
        end
        h ^= h >> 33;
        h *= P2;
        h ^= h >> 29;
        h *= P3;
        h ^= h >> 32;
        return h;
    endfunction

    function automatic void absorb(input beat_t b);
        int n;
        n = (b.cnt > 4'd8) ? 8 : int'(b.cnt);
        for (int i = 0; i < n; i++) begin
            blk[fill] = b.data[8*i +: 8];
            fill++;
            if (fill == 32) begin
                for (int k = 0; k < 4; k++) acc[k] = lane_rnd(acc[k], blk_word(8 * k, 8));
                fill = 0;
            end
        end
        msg_len += 64'(n);
        if (b.last) begin
            hash_q.push_back(finish_hash());
            reseed();
        end
    endfunction

    initial reseed();

    // monitor and checker
    always @(posedge i_clk) begin
        in_taken <= in_ch.valid && in_ch.ready;
        cfg_taken <= cfg_ch.valid && cfg_ch.ready;
        if (i_rst_n) begin
            if (in_ch.valid && in_ch.ready) begin
                absorb(pending[0]);
                pending.pop_front();
            end
            if (cfg_ch.valid && cfg_ch.ready) begin
                seed_r = cfg_ch.data;
                reseed();
            end
            if (out_ch.valid && out_ch.ready) begin
                if (hash_q.size() == 0) begin
                    $error("unexpected hash beat %h", out_ch.hash);
                    errors++;
                end else begin
                    if (out_ch.hash !== hash_q[0]) begin
                        $error("hash: expected %h, actual %h", hash_q[0], out_ch.hash);
                        errors++;
                    end
                    void'(hash_q.pop_front());
                end
            end
            if ((in_ch.valid && in_ch.ready) || (cfg_ch.valid && cfg_ch.ready) ||
                (out_ch.valid && out_ch.ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("[xxhash64_stream] ERROR");
                $finish;
            end
        end
    end

    // input driver: bursts and gaps
    int burst_left = 0;
    int gap_left = 0;
    initial begin
        in_ch.valid = 1'b0;
        in_ch.data = 64'd0;
        in_ch.byte_count = 4'd0;
        in_ch.last = 1'b0;
    end
    always @(negedge i_clk) begin
        if (!(in_ch.valid && !in_taken)) begin
            if (gap_left > 0) begin
                in_ch.valid <= 1'b0;
                gap_left <= gap_left - 1;
            end else if (pending.size() > 0 && i_rst_n) begin
                in_ch.valid <= 1'b1;
                in_ch.data <= pending[0].data;
                in_ch.byte_count <= pending[0].cnt;
                in_ch.last <= pending[0].last;
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(1, 40);
                    gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                in_ch.valid <= 1'b0;
            end
        end
    end

    // result sink: always ready, random ready or mostly stalled, in modes that change at random
    int sink_mode = 0;
    int mode_left = 0;
    initial out_ch.ready = 1'b0;
    always @(negedge i_clk) begin
        if (mode_left == 0) begin
            sink_mode <= $urandom_range(0, 2);
            mode_left <= $urandom_range(50, 400);
        end else begin
            mode_left <= mode_left - 1;
        end
        case (sink_mode)
            0: out_ch.ready <= 1'b1;
            1: out_ch.ready <= $urandom_range(0, 1);
            default: out_ch.ready <= ($urandom_range(0, 5) == 0);
        endcase
    end

    task automatic add_beat(input logic [63:0] d, input int c, input bit l);
        beat_t b;
        b.data = d;
        b.cnt = 4'(c);
        b.last = l;
        pending.push_back(b);
    endtask

    function automatic logic [63:0] rnd64();
        return {$urandom, $urandom};
    endfunction

    task automatic add_message(input bit close);
        int n;
        int c;
        n = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 6) : $urandom_range(5, 40);
        for (int i = 0; i < n; i++) begin
            c = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 15) : $urandom_range(0, 8);
            add_beat(rnd64(), c, close && (i == n - 1));
        end
    endtask

    task automatic wait_idle();
        do @(negedge i_clk); while (pending.size() != 0 || in_ch.valid || hash_q.size() != 0);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_seed(input logic [63:0] s);
        cfg_ch.data = s;
        cfg_ch.valid = 1'b1;
        do @(negedge i_clk); while (!cfg_taken);
        cfg_ch.valid = 1'b0;
    endtask

    logic [63:0] seeds[6];
    initial begin
        cfg_ch.valid = 1'b0;
        cfg_ch.data = 64'd0;
        seeds = '{64'd0, 64'hFFFF_FFFF_FFFF_FFFF, 64'd1, 64'h8000_0000_0000_0000,
                  64'd0, 64'd0};
        seeds[4] = rnd64();
        seeds[5] = rnd64();
        repeat (9) @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed
        add_beat(rnd64(), 0, 1);
        add_beat(rnd64(), 0, 0);
        add_beat(64'hFFFF_FFFF_FFFF_FFFF, 8, 1);
        add_beat(64'd0, 8, 1);
        for (int c = 1; c <= 8; c++) add_beat(rnd64(), c, 1);
        add_beat(rnd64(), 15, 1);
        for (int i = 0; i < 4; i++) add_beat(rnd64(), 8, i == 3);
        for (int i = 0; i < 3; i++) add_beat(rnd64(), 8, 0);
        add_beat(rnd64(), 7, 1);
        for (int i = 0; i < 4; i++) add_beat(rnd64(), 8, 0);
        add_beat(rnd64(), 4, 1);

        for (int ph = 0; ph < 6; ph++) begin
            if (ph > 0) begin
                wait_idle();
                write_seed(seeds[ph]);
            end
            while (pending.size() < 240) add_message(1);
            if (ph == 2) begin
                // partial message dropped by the next seed write
                add_message(0);
            end
        end
        wait_idle();
        if (errors == 0)
            $display("[xxhash64_stream] OK");
        else
            $display("[xxhash64_stream] ERROR");
        $finish;
    end
endmodule
